@@ src/mhtq_pkg.sv @@
// shared types and codes for the min-heap timer queue
`default_nettype none
package mhtq_pkg;

  localparam int ID_BITS    = 8;
  localparam int DELAY_BITS = 16;
  localparam int NOW_BITS   = 32;
  localparam int ALARM_BITS = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_FULL,
    ST_UP_RD,
    ST_UP_CMP,
    ST_LSET,
    ST_LCLR,
    ST_ALARM,
    ST_EMPTY,
    ST_T_CHK,
    ST_T_LIVE,
    ST_T_LAST,
    ST_DN_RD,
    ST_DN_CH1,
    ST_DN_CH2,
    ST_DN_DEC
  } state_t;

endpackage
`default_nettype wire

@@ src/mhtq_ram.sv @@
// generic single-write single-read ram with registered read data
`default_nettype none
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/min_heap_timer_queue_unit.sv @@
// top level of the min-heap timer queue
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready    tdata: timer_id, delay, now; tuser: req_type
//  out_     out  out_tvalid / out_tready  tdata: fired_id, alarm_delay; tuser: result_kind;
//                                         tlast: last
//
// add: parent read and compare per heap level climbed, then live bit set and alarm sent
// tick: per popped entry a check, live read and last-entry fetch, then per level sifted
//   down child reads, a compare and a move, then a placing write; lastly alarm or empty
// cancel: live bit cleared; one output register lets the next item in while a result waits
// after reset a pass clears all ID_COUNT live-map entries; no item is taken then
// a full output register stalls the sequencer only in states that emit a result
`default_nettype none
module min_heap_timer_queue_unit
  import mhtq_pkg::*;
#(
  parameter int HEAP_DEPTH = 32,
  parameter int ID_COUNT   = 256,
  parameter int TIME_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // timer_id[7:0], delay[23:8], now[55:24]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // fired_id[7:0], alarm_delay[39:8]
  output logic [1:0]       out_tuser,  // result_kind[1:0]
  output logic             out_tlast
);

  localparam int TW = TIME_BITS;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int LW = $clog2(ID_COUNT);
  localparam int EW = TW + ID_BITS;

  state_t state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [LW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      hole_r, hole_nxt;
  logic [AW-1:0]      chi_r, chi_nxt;
  logic [TW-1:0]      now_r, now_nxt;
  logic [TW-1:0]      ke_r, ke_nxt;
  logic [ID_BITS-1:0] ki_r, ki_nxt;
  logic [TW-1:0]      che_r, che_nxt;
  logic [ID_BITS-1:0] chd_r, chd_nxt;
  logic [TW-1:0]      tope_r, tope_nxt;
  logic [ID_BITS-1:0] topi_r, topi_nxt;

  logic                  ov_r, ov_nxt;
  kind_t                 okind_r, okind_nxt;
  logic [ID_BITS-1:0]    oid_r, oid_nxt;
  logic [ALARM_BITS-1:0] odly_r, odly_nxt;
  logic                  olast_r, olast_nxt;

  logic          h_we, h_re;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [EW-1:0] h_wdata, h_rdata;
  logic          l_we, l_re;
  logic [LW-1:0] l_waddr, l_raddr;
  logic [0:0]    l_wdata, l_rdata;

  logic [TW-1:0]      r_exp;
  logic [ID_BITS-1:0] r_id;
  logic               slot;
  logic [CW:0]        child;
  logic [CW-1:0]      chi_p1;
  logic [AW-1:0]      parent;
  logic [TW-1:0]      adiff;
  logic [TW+31:0]     adiff_x;
  logic [ALARM_BITS-1:0] alarm;

  mhtq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  mhtq_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_live (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  // live map index as a constant table over every id value
  function automatic logic [LW-1:0] lidx(input logic [ID_BITS-1:0] id);
    lidx = '0;
    for (int i = 0; i < 2**ID_BITS; i++) begin
      if (id == ID_BITS'(i)) begin
        lidx = LW'(i % ID_COUNT);
      end
    end
  endfunction

  assign r_exp  = h_rdata[EW-1:ID_BITS];
  assign r_id   = h_rdata[ID_BITS-1:0];
  assign slot   = !ov_r || out_tready;
  assign child  = ((CW+1)'(hole_r) << 1) + (CW+1)'(1);
  assign chi_p1 = CW'(chi_r) + CW'(1);
  assign parent = (hole_r - AW'(1)) >> 1;
  assign adiff  = (tope_r > now_r) ? (tope_r - now_r) : '0;
  assign adiff_x = {32'b0, adiff};
  assign alarm  = (|(adiff_x >> 32)) ? '1 : adiff_x[31:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {odly_r, oid_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    hole_nxt  = hole_r;
    chi_nxt   = chi_r;
    now_nxt   = now_r;
    ke_nxt    = ke_r;
    ki_nxt    = ki_r;
    che_nxt   = che_r;
    chd_nxt   = chd_r;
    ov_nxt    = out_tready ? 1'b0 : ov_r;
    okind_nxt = okind_r;
    oid_nxt   = oid_r;
    odly_nxt  = odly_r;
    olast_nxt = olast_r;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0;
    h_re = 1'b0; h_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0;
    l_re = 1'b0; l_raddr = '0;

    case (state_r)
      ST_CLR: begin
        l_we    = 1'b1;
        l_waddr = clr_r;
        if (clr_r == LW'(ID_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + LW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          now_nxt = TW'(in_tdata[55:24]);
          ki_nxt  = in_tdata[7:0];
          ke_nxt  = TW'(in_tdata[55:24]) + TW'(in_tdata[23:8]);
          case (in_tuser)
            REQ_ADD: begin
              if (cnt_r == CW'(HEAP_DEPTH)) begin
                state_nxt = ST_FULL;
              end else begin
                hole_nxt  = AW'(cnt_r);
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = ST_UP_RD;
              end
            end
            REQ_CANCEL: state_nxt = ST_LCLR;
            REQ_TICK:   state_nxt = ST_T_CHK;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FULL: begin
        if (slot) begin
          ov_nxt = 1'b1; okind_nxt = KIND_FULL; oid_nxt = '0; odly_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_UP_RD: begin
        if (hole_r == '0) begin
          h_we = 1'b1; h_waddr = hole_r; h_wdata = {ke_r, ki_r};
          state_nxt = ST_LSET;
        end else begin
          h_re = 1'b1; h_raddr = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        h_we = 1'b1; h_waddr = hole_r;
        if (r_exp <= ke_r) begin
          h_wdata   = {ke_r, ki_r};
          state_nxt = ST_LSET;
        end else begin
          h_wdata   = h_rdata;
          hole_nxt  = parent;
          state_nxt = ST_UP_RD;
        end
      end
      ST_LSET: begin
        l_we = 1'b1; l_waddr = lidx(ki_r); l_wdata = 1'b1;
        state_nxt = ST_ALARM;
      end
      ST_LCLR: begin
        l_we = 1'b1; l_waddr = lidx(ki_r); l_wdata = 1'b0;
        state_nxt = ST_IDLE;
      end
      ST_ALARM: begin
        if (slot) begin
          ov_nxt = 1'b1; okind_nxt = KIND_ALARM; oid_nxt = '0; odly_nxt = alarm;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot) begin
          ov_nxt = 1'b1; okind_nxt = KIND_EMPTY; oid_nxt = '0; odly_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_T_CHK: begin
        if (cnt_r == '0) begin
          state_nxt = ST_EMPTY;
        end else if (tope_r <= now_r) begin
          l_re = 1'b1; l_raddr = lidx(topi_r);
          state_nxt = ST_T_LIVE;
        end else begin
          state_nxt = ST_ALARM;
        end
      end
      ST_T_LIVE: begin
        if (!l_rdata[0] || slot) begin
          if (l_rdata[0]) begin
            ov_nxt = 1'b1; okind_nxt = KIND_FIRED; oid_nxt = topi_r; odly_nxt = '0;
            olast_nxt = 1'b0;
          end
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r != CW'(1)) begin
            h_re = 1'b1; h_raddr = AW'(cnt_r - CW'(1));
            state_nxt = ST_T_LAST;
          end else begin
            state_nxt = ST_T_CHK;
          end
        end
      end
      ST_T_LAST: begin
        ke_nxt    = r_exp;
        ki_nxt    = r_id;
        hole_nxt  = '0;
        state_nxt = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (child < (CW+1)'(cnt_r)) begin
          h_re = 1'b1; h_raddr = AW'(child);
          chi_nxt   = AW'(child);
          state_nxt = ST_DN_CH1;
        end else begin
          h_we = 1'b1; h_waddr = hole_r; h_wdata = {ke_r, ki_r};
          state_nxt = ST_T_CHK;
        end
      end
      ST_DN_CH1: begin
        che_nxt = r_exp;
        chd_nxt = r_id;
        if (chi_p1 < cnt_r) begin
          h_re = 1'b1; h_raddr = AW'(chi_p1);
          state_nxt = ST_DN_CH2;
        end else begin
          state_nxt = ST_DN_DEC;
        end
      end
      ST_DN_CH2: begin
        if (r_exp < che_r) begin
          che_nxt = r_exp;
          chd_nxt = r_id;
          chi_nxt = AW'(chi_p1);
        end
        state_nxt = ST_DN_DEC;
      end
      ST_DN_DEC: begin
        h_we = 1'b1; h_waddr = hole_r;
        if (che_r < ke_r) begin
          h_wdata   = {che_r, chd_r};
          hole_nxt  = chi_r;
          state_nxt = ST_DN_RD;
        end else begin
          h_wdata   = {ke_r, ki_r};
          state_nxt = ST_T_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    tope_nxt = tope_r;
    topi_nxt = topi_r;
    if (h_we && h_waddr == '0) begin
      tope_nxt = h_wdata[EW-1:ID_BITS];
      topi_nxt = h_wdata[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    hole_r  <= hole_nxt;
    chi_r   <= chi_nxt;
    now_r   <= now_nxt;
    ke_r    <= ke_nxt;
    ki_r    <= ki_nxt;
    che_r   <= che_nxt;
    chd_r   <= chd_nxt;
    tope_r  <= tope_nxt;
    topi_r  <= topi_nxt;
    okind_r <= okind_nxt;
    oid_r   <= oid_nxt;
    odly_r  <= odly_nxt;
    olast_r <= olast_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r + CW'(1) == $past(cnt_r)))
    else $error("heap count moved by more than one");

  a_heap_wr: assert property (@(posedge clk) disable iff (!rst_n)
    h_we |-> (CW'(h_waddr) < cnt_r))
    else $error("heap write outside occupied region");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (!out_tvalid && !h_we))
    else $error("activity during live map clearing");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// self-checking testbench for the min-heap timer queue unit
`default_nettype none
module tb;
  import mhtq_pkg::*;

  localparam int DEPTH = 32;
  localparam int NIDS = 256;
  localparam int RAND_ITEMS = 150;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    req_t req;
    logic [7:0] id;
    logic [15:0] dly;
    logic [31:0] now;
  } timer_req_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] id;
    logic [31:0] alarm;
    logic last;
  } timer_ev_t;

  // directed row: request plus a hand-typed last result where obvious
  typedef struct packed {
    timer_req_t r;
    logic known;
    timer_ev_t ev;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic in_tready, out_tvalid, out_tlast;
  logic [39:0] out_tdata;
  logic [1:0] out_tuser;

  always #6 clk = ~clk;

  min_heap_timer_queue_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // predictor state
  logic [31:0] heap_exp [DEPTH];
  logic [7:0] heap_id [DEPTH];
  int unsigned heap_n;
  bit live [NIDS];
  timer_ev_t pending_q [$];

  int errors = 0;
  longint cycles = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  function automatic timer_ev_t ev(kind_t k, logic [7:0] i, logic [31:0] a, logic l);
    timer_ev_t e;
    e.kind = k; e.id = i; e.alarm = a; e.last = l;
    return e;
  endfunction

  function automatic logic [31:0] alarm_from(logic [31:0] t);
    return (heap_exp[0] > t) ? heap_exp[0] - t : 32'd0;
  endfunction

  function automatic void pop_top();
    int unsigned hole, c;
    logic [31:0] ke;
    logic [7:0] ki;
    heap_n--;
    if (heap_n == 0) return;
    ke = heap_exp[heap_n];
    ki = heap_id[heap_n];
    hole = 0;
    while (hole * 2 + 1 < heap_n) begin
      c = hole * 2 + 1;
      if (c + 1 < heap_n && heap_exp[c + 1] < heap_exp[c]) c++;
      if (heap_exp[c] < ke) begin
        heap_exp[hole] = heap_exp[c];
        heap_id[hole] = heap_id[c];
        hole = c;
      end else break;
    end
    heap_exp[hole] = ke;
    heap_id[hole] = ki;
  endfunction

  function automatic void predict_timer(timer_req_t r);
    int unsigned hole, p;
    logic [31:0] ex;
    case (r.req)
      REQ_ADD: begin
        if (heap_n >= DEPTH) begin
          pending_q.push_back(ev(KIND_FULL, 8'd0, 32'd0, 1'b1));
        end else begin
          ex = r.now + {16'd0, r.dly};
          hole = heap_n++;
          while (hole > 0) begin
            p = (hole - 1) / 2;
            if (heap_exp[p] <= ex) break;
            heap_exp[hole] = heap_exp[p];
            heap_id[hole] = heap_id[p];
            hole = p;
          end
          heap_exp[hole] = ex;
          heap_id[hole] = r.id;
          live[r.id] = 1'b1;
          pending_q.push_back(ev(KIND_ALARM, 8'd0, alarm_from(r.now), 1'b1));
        end
      end
      REQ_CANCEL: live[r.id] = 1'b0;
      REQ_TICK: begin
        while (heap_n > 0 && heap_exp[0] <= r.now) begin
          if (live[heap_id[0]]) pending_q.push_back(ev(KIND_FIRED, heap_id[0], 32'd0, 1'b0));
          pop_top();
        end
        if (heap_n > 0) pending_q.push_back(ev(KIND_ALARM, 8'd0, alarm_from(r.now), 1'b1));
        else pending_q.push_back(ev(KIND_EMPTY, 8'd0, 32'd0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(timer_req_t r);
    in_tvalid <= 1'b1;
    in_tuser <= r.req;
    in_tdata <= {r.now, r.dly, r.id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_timer(r);
  endtask

  task automatic sender_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic timer_req_t mk(req_t q, logic [7:0] i, logic [15:0] d, logic [31:0] t);
    timer_req_t r;
    r.req = q; r.id = i; r.dly = d; r.now = t;
    return r;
  endfunction

  // output checker
  always @(posedge clk) begin
    timer_ev_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = ev(kind_t'(out_tuser), out_tdata[7:0], out_tdata[39:8], out_tlast);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item kind=%0d id=%0d alarm=%0d last=%0b",
                                   got.kind, got.id, got.alarm, got.last);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind/id/alarm/last=%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     want.kind, want.id, want.alarm, want.last,
                     got.kind, got.id, got.alarm, got.last);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
      end else begin
        g = ($urandom_range(0, 12) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        if (g == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (stim_done == 1'b0 && rst_n);
    repeat (2500) @(posedge clk);
    hold_long = 1'b1;
    repeat (400) @(posedge clk);
    hold_long = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    timer_req_t r;
    logic [31:0] base;
    int n, i, sz;
    for (i = 0; i < NIDS; i++) live[i] = 1'b0;
    heap_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'd0), 1'b1,
                     ev(KIND_EMPTY, 8'd0, 32'd0, 1'b1)});
    rows.push_back('{mk(REQ_ADD, 8'd0, 16'd0, 32'd0), 1'b1,
                     ev(KIND_ALARM, 8'd0, 32'd0, 1'b1)});
    rows.push_back('{mk(REQ_ADD, 8'd255, 16'hFFFF, 32'd0), 1'b1,
                     ev(KIND_ALARM, 8'd0, 32'd0, 1'b1)});
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'd0), 1'b0, '0});
    rows.push_back('{mk(REQ_CANCEL, 8'd255, 16'd0, 32'd0), 1'b0, '0});
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'hFFFF_FFFF), 1'b0, '0});
    rows.push_back('{mk(req_t'(2'd3), 8'd5, 16'd5, 32'd5), 1'b0, '0});
    rows.push_back('{mk(REQ_ADD, 8'd7, 16'hFFFF, 32'hFFFF_FFF0), 1'b0, '0});
    rows.push_back('{mk(REQ_ADD, 8'd7, 16'd3, 32'd100), 1'b0, '0});
    rows.push_back('{mk(REQ_ADD, 8'd9, 16'd3, 32'd100), 1'b0, '0});
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'd200), 1'b0, '0});
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'hFFFF_FFFF), 1'b0, '0});
    rows.push_back('{mk(REQ_CANCEL, 8'd0, 16'd0, 32'd0), 1'b0, '0});
    rows.push_back('{mk(REQ_TICK, 8'd0, 16'd0, 32'd0), 1'b1,
                     ev(KIND_EMPTY, 8'd0, 32'd0, 1'b1)});
    foreach (rows[k]) begin
      send_item(rows[k].r);
      if (rows[k].known && pending_q.size() != 0 && pending_q[$] !== rows[k].ev) begin
        errors++;
        if (errors <= 10) $display("directed row %0d: predictor disagrees with table", k);
      end
      sender_gap();
    end
    // fill to full, then overflow
    wait_drained();
    base = $urandom;
    for (i = 0; i < DEPTH + 2; i++) begin
      send_item(mk(REQ_ADD, 8'($urandom), 16'($urandom), base));
      sender_gap();
    end
    send_item(mk(REQ_TICK, 8'd0, 16'd0, base + 32'h1_0000));
    wait_drained();

    // random: scenarios of adds, cancels and ticks on a moving clock, plus some random-type requests
    base = $urandom;
    n = 0;
    while (n < RAND_ITEMS) begin
      sz = $urandom_range(1, 12);
      for (i = 0; i < sz; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: r = mk(REQ_ADD, 8'($urandom_range(0, 31) | ($urandom_range(0, 7) == 0 ?
                                8'($urandom) : 8'd0)), 16'($urandom_range(0, 300) |
                                ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'd0)), base);
          5, 6: r = mk(REQ_CANCEL, 8'($urandom_range(0, 31)), 16'($urandom), base);
          7, 8: begin
            base = base + $urandom_range(0, 200);
            r = mk(REQ_TICK, 8'($urandom), 16'($urandom), base);
          end
          default: r = mk(req_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), $urandom);
        endcase
        if (r.req != 2'd3) n++;
        send_item(r);
        sender_gap();
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);
    stim_done = 1'b1;
    if (errors == 0 && pending_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
